// ===== src/assert_macros.svh =====
// Assertion helpers for the handle table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/ght_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ght_pkg;

  localparam int SLOTS_DEF    = 256;
  localparam int GEN_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int SLOT_BITS    = 8;
  localparam int OPCODE_BITS  = 2;
  localparam int STATUS_BITS  = 2;

  localparam logic [OPCODE_BITS-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_RESOLVE = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_RELEASE = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_STALE = 2'd3;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]  opcode;
    logic [SLOT_BITS-1:0]    slot_index;
    logic [GEN_BITS-1:0]     handle_generation;
    logic [PAYLOAD_BITS-1:0] payload_in;
  } in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [SLOT_BITS-1:0]    slot_out;
    logic [GEN_BITS-1:0]     generation_out;
    logic [PAYLOAD_BITS-1:0] payload_out;
  } out_t;

  // One record memory word per slot.
  typedef struct packed {
    logic                    live;
    logic [GEN_BITS-1:0]     gen;
    logic [PAYLOAD_BITS-1:0] payload;
  } rec_t;

endpackage

`default_nettype wire

// ===== src/ght_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/generational_handle_table.sv =====
// Allocate from a never-used slot, full, out-of-range and unused opcodes answer straight
// from idle. Resolve and release in range take one record memory read. Allocate from the
// free stack takes a stack read then a record read. A new item is taken only when busy is
// low; busy covers the memory reads and the receiver cannot stall.
// Reset (rst_ni low, asynchronous) empties the free stack and the high-water mark; no
// clearing pass runs, since slots at or above the high-water mark count as fresh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module generational_handle_table #(
  parameter int SLOTS = ght_pkg::SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire ght_pkg::in_t item_i,
  output      logic        result_valid_o,
  output      ght_pkg::out_t result_o
);

  import ght_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int REC_W = $bits(rec_t);

  // The controller walks one item at a time through at most two memory reads.
  typedef enum logic [3:0] {
    S_IDLE     = 4'b0001,
    S_POP      = 4'b0010,
    S_ALLOC_RD = 4'b0100,
    S_CHECK    = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  in_t               item_q, item_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic [CNT_W-1:0]  free_count_q, free_count_d;
  logic [CNT_W-1:0]  hwm_q, hwm_d;
  out_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              rec_we, rec_re;
  logic [IDX_W-1:0]  rec_waddr, rec_raddr;
  rec_t              rec_wdata, rec_rdata;
  logic [REC_W-1:0]  rec_rdata_raw;

  logic              stk_we, stk_re;
  logic [IDX_W-1:0]  stk_waddr, stk_raddr;
  logic [IDX_W-1:0]  stk_wdata, stk_rdata;

  logic              accept;
  logic              handle_ok;

  // Record memory: live mark, generation and payload of every slot. Entries at or
  // above the high-water mark are never read; the first allocate of a slot writes
  // generation zero, which is what reset would have left there.
  ght_ram #(
    .WIDTH(REC_W),
    .DEPTH(SLOTS)
  ) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (rec_we),
    .waddr_i(rec_waddr),
    .wdata_i(rec_wdata),
    .re_i   (rec_re),
    .raddr_i(rec_raddr),
    .rdata_o(rec_rdata_raw)
  );

  assign rec_rdata = rec_t'(rec_rdata_raw);

  // Free stack of released slots; only entries below the free count are read.
  ght_ram #(
    .WIDTH(IDX_W),
    .DEPTH(SLOTS)
  ) u_stk_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign accept         = start && !busy;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // A handle is good when its slot is live and the generations agree.
  assign handle_ok = rec_rdata.live && (rec_rdata.gen == item_q.handle_generation);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    slot_d       = slot_q;
    free_count_d = free_count_q;
    hwm_d        = hwm_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;

    rec_we    = 1'b0;
    rec_waddr = slot_q;
    rec_wdata = '0;
    rec_re    = 1'b0;
    rec_raddr = slot_q;
    stk_we    = 1'b0;
    stk_waddr = IDX_W'(free_count_q);
    stk_wdata = slot_q;
    stk_re    = 1'b0;
    stk_raddr = IDX_W'(free_count_q - CNT_W'(1));

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d = item_i;
          unique case (item_i.opcode) inside
            OP_ALLOC: begin
              if (free_count_q != '0) begin
                // Reuse the most recently released slot.
                stk_re       = 1'b1;
                free_count_d = free_count_q - CNT_W'(1);
                state_d      = S_POP;
              end else if (hwm_q < CNT_W'(SLOTS)) begin
                // Fresh slot: its generation is still zero, no read needed.
                rec_we            = 1'b1;
                rec_waddr         = IDX_W'(hwm_q);
                rec_wdata.live    = 1'b1;
                rec_wdata.gen     = '0;
                rec_wdata.payload = item_i.payload_in;
                hwm_d             = hwm_q + CNT_W'(1);
                res_d             = '{status: ST_OK, slot_out: SLOT_BITS'(hwm_q),
                                      generation_out: '0, payload_out: '0};
                res_valid_d       = 1'b1;
              end else begin
                res_d       = '{status: ST_FULL, slot_out: '0,
                                generation_out: '0, payload_out: '0};
                res_valid_d = 1'b1;
              end
            end
            OP_RESOLVE, OP_RELEASE: begin
              if (32'(item_i.slot_index) >= 32'(hwm_q)) begin
                res_d       = '{status: ST_RANGE, slot_out: item_i.slot_index,
                                generation_out: '0, payload_out: '0};
                res_valid_d = 1'b1;
              end else begin
                rec_re    = 1'b1;
                rec_raddr = IDX_W'(item_i.slot_index);
                slot_d    = IDX_W'(item_i.slot_index);
                state_d   = S_CHECK;
              end
            end
            default: begin
              // The unused opcode answers ok with all other fields zero.
              res_d       = '{status: ST_OK, slot_out: '0,
                              generation_out: '0, payload_out: '0};
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        rec_re    = 1'b1;
        rec_raddr = stk_rdata;
        slot_d    = stk_rdata;
        state_d   = S_ALLOC_RD;
      end
      S_ALLOC_RD: begin
        // The reused slot keeps the generation that its release left.
        rec_we            = 1'b1;
        rec_wdata.live    = 1'b1;
        rec_wdata.gen     = rec_rdata.gen;
        rec_wdata.payload = item_q.payload_in;
        res_d             = '{status: ST_OK, slot_out: SLOT_BITS'(slot_q),
                              generation_out: rec_rdata.gen, payload_out: '0};
        res_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end
      S_CHECK: begin
        res_d.status         = handle_ok ? ST_OK : ST_STALE;
        res_d.slot_out       = item_q.slot_index;
        res_d.generation_out = '0;
        res_d.payload_out    = '0;
        if (item_q.opcode == OP_RESOLVE && handle_ok) begin
          res_d.payload_out = rec_rdata.payload;
        end
        if (item_q.opcode == OP_RELEASE && handle_ok) begin
          // Kill the slot, bump its generation and push it on the free stack.
          rec_we            = 1'b1;
          rec_wdata.live    = 1'b0;
          rec_wdata.gen     = rec_rdata.gen + GEN_BITS'(1);
          rec_wdata.payload = rec_rdata.payload;
          if (free_count_q < CNT_W'(SLOTS)) begin
            stk_we       = 1'b1;
            free_count_d = free_count_q + CNT_W'(1);
          end
        end
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_count_q <= '0;
      hwm_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      hwm_q        <= hwm_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  // Every released slot was handed out before, so the stack never outgrows it.
  `ASSERT_CLK(a_free_le_hwm, free_count_q <= hwm_q, "free count above high-water mark")
  `ASSERT_CLK(a_hwm_range, hwm_q <= CNT_W'(SLOTS), "high-water mark beyond table size")
  // An accepted item either answers at once or enters a memory read state.
  `ASSERT_CLK(a_accept_progress, accept |=> (busy || result_valid_o),
              "accepted item neither answered nor in progress")
  `ASSERT_CLK(a_no_result_busy, busy |-> !result_valid_o, "result while still busy")

endmodule

`default_nettype wire

// ===== test/tb_generational_handle_table.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the generational handle table. A driver pulls items from a
// queue and offers them on the start/busy handshake. Each accepted item runs through
// a shadow copy of the table, and the expected result goes into a queue. A monitor
// compares every strobed result with the oldest expected one. The receiver cannot stall,
// so all idling is on the sending side.
module tb_generational_handle_table;
  import ght_pkg::*;

  localparam int NUM_SLOTS = SLOTS_DEF;
  // The fourth opcode value has no operation behind it and must answer all zeros.
  localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
  // Release and reallocate rounds on a single slot.
  localparam int REUSE_PAIRS = 40;
  // Cycles to wait after the last result, longer than the slowest operation.
  localparam int DRAIN_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  item_i = '0;
  logic result_valid_o;
  out_t result_o;

  generational_handle_table #(
    .SLOTS(NUM_SLOTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the table contents. The free stack is a queue whose last entry is the top.
  logic [PAYLOAD_BITS-1:0] rec_payload [NUM_SLOTS];
  logic                    rec_live    [NUM_SLOTS];
  logic [GEN_BITS-1:0]     rec_gen     [NUM_SLOTS];
  logic [SLOT_BITS-1:0]    free_slots  [$];
  int                      high_water;

  in_t  pending_items    [$];
  out_t expected_results [$];
  int   idle_left = 0;
  int   gap_max = 0;
  int   mismatch_count = 0;

  // A handle is good only if its slot was handed out at some point, the slot is live,
  // and the generation matches the one the slot holds now.
  function automatic logic [STATUS_BITS-1:0] handle_status(in_t it);
    if (int'(it.slot_index) >= high_water) return ST_RANGE;
    if (!rec_live[it.slot_index] || rec_gen[it.slot_index] != it.handle_generation)
      return ST_STALE;
    return ST_OK;
  endfunction

  // Applies one item to the shadow table and returns the result it should produce.
  function automatic out_t apply_table_op(in_t it);
    out_t                 res;
    logic [SLOT_BITS-1:0] s;
    logic                 granted;
    res = '0;
    case (it.opcode)
      OP_ALLOC: begin
        // Recently released slots are reused first. Otherwise the next fresh slot is
        // taken, and when neither exists the table is full.
        granted = 1'b1;
        s = '0;
        if (free_slots.size() != 0) begin
          s = free_slots[$];
          free_slots.delete(free_slots.size() - 1);
        end else if (high_water < NUM_SLOTS) begin
          s = SLOT_BITS'(high_water);
          high_water++;
        end else begin
          granted = 1'b0;
        end
        if (granted) begin
          rec_payload[s] = it.payload_in;
          rec_live[s] = 1'b1;
          res.status = ST_OK;
          res.slot_out = s;
          res.generation_out = rec_gen[s];
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_RESOLVE: begin
        res.status = handle_status(it);
        res.slot_out = it.slot_index;
        if (res.status == ST_OK) res.payload_out = rec_payload[it.slot_index];
      end
      OP_RELEASE: begin
        res.status = handle_status(it);
        res.slot_out = it.slot_index;
        if (res.status == ST_OK) begin
          // The generation wraps at its width, so old handles eventually match again.
          rec_live[it.slot_index] = 1'b0;
          rec_payload[it.slot_index] = '0;
          rec_gen[it.slot_index] = rec_gen[it.slot_index] + GEN_BITS'(1);
          free_slots.insert(free_slots.size(), it.slot_index);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Driver. The expected result is computed at the edge where the item is taken. The
  // next item goes out at the same edge, unless the drawn idle time says to wait.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.insert(expected_results.size(), apply_table_op(item_i));
        idle_left = $urandom_range(0, gap_max);
      end
      if (!start || !busy) begin
        if (idle_left == 0 && pending_items.size() != 0) begin
          item_i <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          if (idle_left > 0) idle_left--;
          start <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [PAYLOAD_BITS-1:0] want,
                               logic [PAYLOAD_BITS-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor. A result stays valid for one cycle only, so it is taken at every edge
  // that sees the strobe.
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: status %0d slot %0d",
               result_o.status, result_o.slot_out);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", PAYLOAD_BITS'(want.status), PAYLOAD_BITS'(result_o.status));
        compare_field("slot_out", PAYLOAD_BITS'(want.slot_out),
                      PAYLOAD_BITS'(result_o.slot_out));
        compare_field("generation_out", PAYLOAD_BITS'(want.generation_out),
                      PAYLOAD_BITS'(result_o.generation_out));
        compare_field("payload_out", want.payload_out, result_o.payload_out);
      end
    end
  end

  function automatic in_t make_item(logic [OPCODE_BITS-1:0] op, logic [SLOT_BITS-1:0] slot,
                                    logic [GEN_BITS-1:0] gen, logic [PAYLOAD_BITS-1:0] pay);
    in_t it;
    it.opcode = op;
    it.slot_index = slot;
    it.handle_generation = gen;
    it.payload_in = pay;
    return it;
  endfunction

  // Appends one item to the driver's queue.
  task automatic queue_item(in_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Payloads lean toward the two extremes now and then.
  function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PAYLOAD_BITS'($urandom());
    endcase
  endfunction

  // Adds an allocate item. Its handle fields are ignored by the block but still
  // random, so their bits toggle.
  task automatic push_alloc();
    queue_item(make_item(OP_ALLOC, SLOT_BITS'($urandom()),
                         GEN_BITS'($urandom()), pick_payload()));
  endtask

  // Blocks until the driver has handed over every queued item.
  task automatic wait_sent();
    while (pending_items.size() != 0 || start) @(negedge clk_i);
  endtask

  // Blocks until the block is idle with nothing left to check.
  task automatic wait_results();
    wait_sent();
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Builds a short run of items from the current table contents: allocates, releases,
  // resolves on live handles, and noise: stale generations, slots past the
  // high-water mark, the unused opcode, and fully random items. Handles are chosen when
  // the run is built, so a release early in the run can make a later handle stale.
  task automatic add_random_batch(int alloc_w, int release_w, int n);
    logic [SLOT_BITS-1:0] live [$];
    logic [SLOT_BITS-1:0] s;
    logic [GEN_BITS-1:0]  g;
    logic [OPCODE_BITS-1:0] op;
    int roll;
    for (int i = 0; i < NUM_SLOTS; i++) if (rec_live[i]) live.insert(live.size(), SLOT_BITS'(i));
    repeat (n) begin
      roll = $urandom_range(0, 99);
      s = (live.size() != 0) ? live[$urandom_range(0, live.size() - 1)]
                             : SLOT_BITS'($urandom());
      g = rec_gen[s];
      op = ($urandom_range(0, 1) != 0) ? OP_RESOLVE : OP_RELEASE;
      if (roll < alloc_w) begin
        push_alloc();
      end else if (roll < alloc_w + release_w) begin
        queue_item(make_item(OP_RELEASE, s, g, pick_payload()));
      end else if (roll < 85) begin
        queue_item(make_item(OP_RESOLVE, s, g, pick_payload()));
      end else begin
        case ($urandom_range(0, 3))
          0: queue_item(make_item(op, s,
                 g ^ GEN_BITS'($urandom_range(1, (1 << GEN_BITS) - 1)), pick_payload()));
          1: begin
            if (high_water < NUM_SLOTS) s = SLOT_BITS'($urandom_range(high_water, NUM_SLOTS - 1));
            queue_item(make_item(op, s, g, pick_payload()));
          end
          2: queue_item(make_item(OPCODE_BITS'($urandom()), SLOT_BITS'($urandom()),
                 GEN_BITS'($urandom()), PAYLOAD_BITS'($urandom())));
          default: queue_item(make_item(OP_UNUSED, SLOT_BITS'($urandom()),
                 GEN_BITS'($urandom()), PAYLOAD_BITS'($urandom())));
        endcase
      end
    end
  endtask

  // Sends count random items in short runs. About one run in four goes back to back;
  // the others idle a random time before each item.
  task automatic run_random(int alloc_w, int release_w, int count);
    int n;
    while (count > 0) begin
      n = $urandom_range(1, 6);
      if (n > count) n = count;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      add_random_batch(alloc_w, release_w, n);
      wait_sent();
      count -= n;
    end
  endtask

  initial begin : stimulus
    int wrap_slot;
    logic [GEN_BITS-1:0] wrap_gen;
    wrap_slot = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rec_payload[i] = '0;
      rec_live[i] = 1'b0;
      rec_gen[i] = '0;
    end
    high_water = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items, back to back, so that items touching the same slot come right
    // after one another. The table is empty at first, so every handle is out of range.
    gap_max = 0;
    queue_item(make_item(OP_RESOLVE, '0, '0, '0));
    queue_item(make_item(OP_RELEASE, '1, '1, '1));
    queue_item(make_item(OP_UNUSED, '1, '1, '1));
    // Fresh slots 0, 1 and 2, holding the two payload extremes and a middle value.
    queue_item(make_item(OP_ALLOC, '1, '1, '0));
    queue_item(make_item(OP_ALLOC, '0, '0, '1));
    queue_item(make_item(OP_ALLOC, 8'h5a, 16'h1234, 32'h1234_5678));
    queue_item(make_item(OP_RESOLVE, 8'd0, 16'd0, '1));
    queue_item(make_item(OP_RESOLVE, 8'd1, 16'd0, '0));
    // Wrong generation on a live slot, then the first slot past the high-water mark.
    queue_item(make_item(OP_RESOLVE, 8'd1, '1, '0));
    queue_item(make_item(OP_RESOLVE, 8'd3, 16'd0, '0));
    // Release, then use the old handle again, and try the next generation on the
    // dead slot.
    queue_item(make_item(OP_RELEASE, 8'd1, 16'd0, '0));
    queue_item(make_item(OP_RESOLVE, 8'd1, 16'd0, '0));
    queue_item(make_item(OP_RELEASE, 8'd1, 16'd0, '0));
    queue_item(make_item(OP_RELEASE, 8'd1, 16'd1, '0));
    // Reuse from the free stack, resolved right away under the new generation.
    queue_item(make_item(OP_ALLOC, '0, '0, 32'hcafe_f00d));
    queue_item(make_item(OP_RESOLVE, 8'd1, 16'd1, '0));
    // Two releases, then two allocates that must come back last in, first out.
    queue_item(make_item(OP_RELEASE, 8'd0, 16'd0, '0));
    queue_item(make_item(OP_RELEASE, 8'd2, 16'd0, '0));
    push_alloc();
    push_alloc();
    // With the stack empty again, the next allocate takes a fresh slot.
    queue_item(make_item(OP_ALLOC, '0, '0, 32'h5a5a_5a5a));
    queue_item(make_item(OP_RESOLVE, 8'd3, 16'd0, '0));
    queue_item(make_item(OP_RELEASE, 8'd3, 16'd0, '0));
    queue_item(make_item(OP_RESOLVE, 8'd3, 16'd1, '0));
    // Hold off until the block has answered everything before going random.
    wait_results();

    // Random traffic that leans toward allocates, so the table fills up.
    run_random(45, 15, 350);

    // Fill every slot, then allocate a few more times against a full table.
    while (high_water < NUM_SLOTS || free_slots.size() != 0) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 13;
      add_random_batch(92, 0, $urandom_range(1, 6));
      wait_sent();
    end
    gap_max = 0;
    push_alloc();
    push_alloc();
    queue_item(make_item(OP_RESOLVE, '1, GEN_BITS'($urandom()), '0));
    push_alloc();
    wait_results();

    // Drain the table mostly, then run balanced traffic.
    run_random(20, 45, 300);
    run_random(30, 30, 300);

    // Repeated reuse: release and reallocate one slot many times in a row. Last in,
    // first out means each allocate returns that slot with the next generation.
    wait_results();
    gap_max = 0;
    for (int i = 0; i < NUM_SLOTS; i++) if (wrap_slot < 0 && rec_live[i]) wrap_slot = i;
    if (wrap_slot < 0) begin
      push_alloc();
      wait_sent();
      for (int i = 0; i < NUM_SLOTS; i++) if (wrap_slot < 0 && rec_live[i]) wrap_slot = i;
    end
    wrap_gen = rec_gen[wrap_slot];
    for (int k = 0; k < REUSE_PAIRS; k++) begin
      queue_item(make_item(OP_RELEASE, SLOT_BITS'(wrap_slot),
                           GEN_BITS'(wrap_gen + k), '0));
      push_alloc();
    end
    // The latest generation resolves, and the one before it is stale.
    queue_item(make_item(OP_RESOLVE, SLOT_BITS'(wrap_slot),
                         GEN_BITS'(wrap_gen + REUSE_PAIRS), '0));
    queue_item(make_item(OP_RESOLVE, SLOT_BITS'(wrap_slot),
                         GEN_BITS'(wrap_gen + REUSE_PAIRS - 1), '0));

    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS generational_handle_table");
    end else begin
      $display("FAIL generational_handle_table");
    end
    $finish;
  end

  // Safety stop, several times the slowest correct run.
  initial begin
    #6_000_000;
    $display("FAIL generational_handle_table");
    $finish;
  end

endmodule
